// ===== design/nsm_pkg.sv =====
`default_nettype none

package nsm_pkg;

    typedef enum logic [2:0] {
        ST_NONE       = 3'd0,
        ST_INCOMPLETE = 3'd1,
        ST_REACHABLE  = 3'd2,
        ST_STALE      = 3'd3,
        ST_DELAY      = 3'd4,
        ST_PROBE      = 3'd5
    } t_state;

    typedef enum logic [2:0] {
        OP_NS_IN          = 3'd0,
        OP_NA_IN          = 3'd1,
        OP_PKT_OUT        = 3'd2,
        OP_RETRANSMIT_EXP = 3'd3,
        OP_DELAY_EXP      = 3'd4,
        OP_REACHABLE_EXP  = 3'd5,
        OP_FORCE_STATE    = 3'd6
    } t_op;

    localparam logic [1:0] REG_RETRANSMIT  = 2'd0;
    localparam logic [1:0] REG_DELAY       = 2'd1;
    localparam logic [1:0] REG_REACHABLE   = 2'd2;
    localparam logic [1:0] REG_MAX_RETRIES = 2'd3;

    localparam logic [15:0] RETRANSMIT_RESET  = 16'd1000;
    localparam logic [15:0] DELAY_RESET       = 16'd5000;
    localparam logic [15:0] REACHABLE_RESET   = 16'd30000;
    localparam logic [3:0]  MAX_RETRIES_RESET = 4'd6;

    localparam logic [3:0] RETRY_MAX = 4'd15;

    typedef struct packed {
        logic [15:0] retransmit_ms;
        logic [15:0] delay_ms;
        logic [15:0] reachable_ms;
        logic [3:0]  max_retries;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  operation;
        logic [47:0] peer_mac;
        logic        solicited_flag;
        logic        override_flag;
        logic        route_already_absent;
        logic [2:0]  forced_state;
        logic [3:0]  forced_retry;
    } t_event;

    typedef struct packed {
        t_state      cur_state;
        t_state      prior_state;
        logic [47:0] cached_mac;
        logic [3:0]  retries;
        logic        send_solicit;
        logic        start_retransmit;
        logic        start_delay;
        logic        start_reachable;
        logic        delete_route;
        logic        resolved;
    } t_result;

endpackage

`default_nettype wire

// ===== design/nsm_regs.sv =====
`default_nettype none

module nsm_regs
    import nsm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;
    logic w_write;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.retransmit_ms <= RETRANSMIT_RESET;
            r_cfg.delay_ms      <= DELAY_RESET;
            r_cfg.reachable_ms  <= REACHABLE_RESET;
            r_cfg.max_retries   <= MAX_RETRIES_RESET;
        end else if (w_write) begin
            unique case (paddr[3:2])
                REG_RETRANSMIT:  r_cfg.retransmit_ms <= pwdata[15:0];
                REG_DELAY:       r_cfg.delay_ms      <= pwdata[15:0];
                REG_REACHABLE:   r_cfg.reachable_ms  <= pwdata[15:0];
                REG_MAX_RETRIES: r_cfg.max_retries   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_RETRANSMIT:  prdata = {16'd0, r_cfg.retransmit_ms};
            REG_DELAY:       prdata = {16'd0, r_cfg.delay_ms};
            REG_REACHABLE:   prdata = {16'd0, r_cfg.reachable_ms};
            REG_MAX_RETRIES: prdata = {28'd0, r_cfg.max_retries};
            default:         prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== design/nsm_fsm.sv =====
`default_nettype none

module nsm_fsm
    import nsm_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire t_event i_event,
    input  wire logic   i_step,
    output t_result     o_result
);

    t_state      r_state;
    t_state      r_prev;
    logic [47:0] r_mac;
    logic [3:0]  r_retry;

    t_state      n_state;
    t_state      n_prev;
    logic [47:0] n_mac;
    logic [3:0]  n_retry;

    t_state      goto_tgt;
    logic        do_goto;
    logic        differs;
    logic        retry_ok;
    logic        retx_en;
    logic [3:0]  retry_inc;
    logic        req_solicit;
    logic        req_retx;
    logic        req_delay;
    logic        req_reach;
    logic        req_delete;

    assign differs   = i_event.peer_mac != r_mac;
    assign retry_ok  = r_retry < i_cfg.max_retries;
    assign retx_en   = i_cfg.retransmit_ms != 16'd0;
    assign retry_inc = (r_retry == RETRY_MAX) ? r_retry : r_retry + 4'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_NONE;
            r_prev  <= ST_NONE;
            r_mac   <= 48'd0;
            r_retry <= 4'd0;
        end else if (i_step) begin
            r_state <= n_state;
            r_prev  <= n_prev;
            r_mac   <= n_mac;
            r_retry <= n_retry;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_prev      = r_prev;
        n_mac       = r_mac;
        n_retry     = r_retry;
        do_goto     = 1'b0;
        goto_tgt    = r_state;
        req_solicit = 1'b0;
        req_retx    = 1'b0;
        req_delay   = 1'b0;
        req_reach   = 1'b0;
        req_delete  = 1'b0;

        unique case (i_event.operation)
            OP_NS_IN: begin
                priority if (r_state == ST_NONE) begin
                    n_mac    = i_event.peer_mac;
                    do_goto  = 1'b1;
                    goto_tgt = ST_STALE;
                end else if (r_state == ST_STALE) begin
                    n_mac = i_event.peer_mac;
                end else if (differs) begin
                    n_mac    = i_event.peer_mac;
                    do_goto  = 1'b1;
                    goto_tgt = ST_STALE;
                end
            end
            OP_NA_IN: begin
                priority if (r_state == ST_INCOMPLETE) begin
                    n_mac    = i_event.peer_mac;
                    do_goto  = 1'b1;
                    goto_tgt = i_event.solicited_flag ? ST_REACHABLE : ST_STALE;
                end else if (r_state == ST_NONE) begin
                end else if (!i_event.solicited_flag) begin
                    if (i_event.override_flag && differs) begin
                        n_mac    = i_event.peer_mac;
                        do_goto  = 1'b1;
                        goto_tgt = ST_STALE;
                    end
                end else if (r_state == ST_REACHABLE) begin
                    if (!i_event.override_flag) begin
                        if (differs) begin
                            do_goto  = 1'b1;
                            goto_tgt = ST_STALE;
                        end
                    end else begin
                        n_mac = i_event.peer_mac;
                    end
                end else if (i_event.override_flag) begin
                    n_mac    = i_event.peer_mac;
                    do_goto  = 1'b1;
                    goto_tgt = ST_REACHABLE;
                end
            end
            OP_PKT_OUT: begin
                priority if (r_state == ST_NONE) begin
                    req_solicit = 1'b1;
                    if (retx_en) begin
                        n_retry  = retry_inc;
                        req_retx = 1'b1;
                    end
                    do_goto  = 1'b1;
                    goto_tgt = ST_INCOMPLETE;
                end else if (r_state == ST_STALE) begin
                    req_delay = i_cfg.delay_ms != 16'd0;
                    do_goto   = 1'b1;
                    goto_tgt  = ST_DELAY;
                end
            end
            OP_RETRANSMIT_EXP: begin
                priority if (r_state == ST_INCOMPLETE || r_state == ST_PROBE) begin
                    if (retry_ok) begin
                        req_solicit = 1'b1;
                        if (retx_en) begin
                            n_retry  = retry_inc;
                            req_retx = 1'b1;
                        end
                    end else begin
                        req_delete = 1'b1;
                        if (!i_event.route_already_absent) begin
                            n_retry = 4'd0;
                        end
                    end
                end else if (r_state == ST_REACHABLE) begin
                    if (retry_ok) begin
                        req_solicit = 1'b1;
                        if (retx_en) begin
                            n_retry  = retry_inc;
                            req_retx = 1'b1;
                        end
                    end else begin
                        do_goto  = 1'b1;
                        goto_tgt = ST_STALE;
                    end
                end
            end
            OP_DELAY_EXP: begin
                if (r_state == ST_DELAY || r_state == ST_PROBE) begin
                    req_solicit = 1'b1;
                    if (retx_en) begin
                        n_retry  = retry_inc;
                        req_retx = 1'b1;
                    end
                    do_goto  = 1'b1;
                    goto_tgt = ST_PROBE;
                end
            end
            OP_REACHABLE_EXP: begin
                if (r_state == ST_REACHABLE) begin
                    do_goto  = 1'b1;
                    goto_tgt = ST_STALE;
                end
            end
            OP_FORCE_STATE: begin
                n_mac = 48'd0;
                if (r_state == ST_STALE) begin
                    n_retry = i_event.forced_retry;
                end
                if (i_event.forced_state <= 3'(ST_PROBE)) begin
                    do_goto  = 1'b1;
                    goto_tgt = t_state'(i_event.forced_state);
                end
            end
            default: ;
        endcase

        if (do_goto) begin
            if (goto_tgt != r_state) begin
                n_prev  = r_state;
                n_state = goto_tgt;
            end
            unique case (goto_tgt)
                ST_INCOMPLETE, ST_DELAY, ST_PROBE: n_retry = 4'd0;
                ST_REACHABLE: req_reach = i_cfg.reachable_ms != 16'd0;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_result.cur_state        = n_state;
        o_result.prior_state      = n_prev;
        o_result.cached_mac       = n_mac;
        o_result.retries          = n_retry;
        o_result.send_solicit     = req_solicit;
        o_result.start_retransmit = req_retx;
        o_result.start_delay      = req_delay;
        o_result.start_reachable  = req_reach;
        o_result.delete_route     = req_delete;
        o_result.resolved         = (n_state != ST_NONE) && (n_state != ST_INCOMPLETE);
    end

endmodule

`default_nettype wire

// ===== design/ipv6_neighbor_state_machine.sv =====
// IPv6 neighbor cache entry state machine for one neighbor.
// Input channel: i_in_valid / o_in_stall carry one event word (operation,
// MAC, advertisement flags, forced state and retry). A word is taken at a
// rising edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall carry one result word per event:
// new state, prior state, cached MAC, retry count, the solicit, timer start
// and route delete requests, and the resolved flag.
// An event that is taken is registered in the input stage, runs through
// the next-state logic and lands in the result register when no stalled
// result holds the output. Throughput: one event per cycle while no result
// is stalled; the entry state updates in the same cycle that the event
// moves from the input stage to the result register.
// Stall: while i_out_stall holds a result, the input stage keeps one more
// event and then raises o_in_stall; nothing is dropped.
// Reset (i_rst_n low, synchronous): both stages empty, state none, prior
// state none, MAC and retry count zero, registers to 1000/5000/30000/6.
// Configuration: APB registers retransmit_ms, delay_ms, reachable_ms and
// max_retries at byte addresses 0, 4, 8 and 12; pready is always high.
`default_nettype none

module ipv6_neighbor_state_machine
    import nsm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_operation,
    input  wire logic [47:0] i_peer_mac,
    input  wire logic        i_solicited_flag,
    input  wire logic        i_override_flag,
    input  wire logic        i_route_already_absent,
    input  wire logic [2:0]  i_forced_state,
    input  wire logic [3:0]  i_forced_retry,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [2:0]  o_cur_state,
    output logic      [2:0]  o_prior_state,
    output logic      [47:0] o_cached_mac,
    output logic      [3:0]  o_retries,
    output logic             o_send_solicit,
    output logic             o_start_retransmit,
    output logic             o_start_delay,
    output logic             o_start_reachable,
    output logic             o_delete_route,
    output logic             o_resolved
);

    t_cfg    w_cfg;
    t_result w_result;
    logic    w_adv;
    logic    w_take;

    logic    r_in_valid;
    t_event  r_event;
    logic    r_out_valid;
    t_result r_result;

    nsm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_adv      = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_take     = i_in_valid && !o_in_stall;

    nsm_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_event  (r_event),
        .i_step   (r_in_valid && w_adv),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_event.operation            <= i_operation;
            r_event.peer_mac             <= i_peer_mac;
            r_event.solicited_flag       <= i_solicited_flag;
            r_event.override_flag        <= i_override_flag;
            r_event.route_already_absent <= i_route_already_absent;
            r_event.forced_state         <= i_forced_state;
            r_event.forced_retry         <= i_forced_retry;
        end
        if (w_adv && r_in_valid) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_cur_state        = r_result.cur_state;
    assign o_prior_state      = r_result.prior_state;
    assign o_cached_mac       = r_result.cached_mac;
    assign o_retries          = r_result.retries;
    assign o_send_solicit     = r_result.send_solicit;
    assign o_start_retransmit = r_result.start_retransmit;
    assign o_start_delay      = r_result.start_delay;
    assign o_start_reachable  = r_result.start_reachable;
    assign o_delete_route     = r_result.delete_route;
    assign o_resolved         = r_result.resolved;

endmodule

`default_nettype wire

// ===== design/nsm_checker.sv =====
`default_nettype none

module nsm_checker
    import nsm_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [2:0]  o_cur_state,
    input wire logic [47:0] o_cached_mac,
    input wire logic        o_send_solicit,
    input wire logic        o_start_retransmit,
    input wire logic        o_start_delay,
    input wire logic        o_delete_route,
    input wire logic        o_resolved
);

    a_resolved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_resolved ==
            (o_cur_state != 3'(ST_NONE) && o_cur_state != 3'(ST_INCOMPLETE))))
        else $error("resolved flag disagrees with state");

    a_retx_solicit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_start_retransmit) |-> (o_send_solicit && !o_delete_route))
        else $error("retransmit start without solicitation");

    a_delete_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_delete_route) |->
            (o_cur_state == 3'(ST_INCOMPLETE) || o_cur_state == 3'(ST_PROBE)))
        else $error("route delete outside incomplete or probe");

    a_delay_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_start_delay) |-> (o_cur_state == 3'(ST_DELAY)))
        else $error("delay timer start outside delay state");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_cur_state) && $stable(o_cached_mac)))
        else $error("stalled result word changed");

endmodule

bind ipv6_neighbor_state_machine nsm_checker u_nsm_checker (.*);

`default_nettype wire

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nsm_pkg::*;

    localparam logic [2:0] OP_UNDEFINED  = 3'd7;
    localparam logic [2:0] FST_UNDEF_LO  = 3'd6;
    localparam logic [2:0] FST_UNDEF_HI  = 3'd7;

    // request bits: solicit, retransmit, delay, reachable, delete
    localparam logic [4:0] REQ_NONE      = 5'b00000;
    localparam logic [4:0] REQ_SOLICIT   = 5'b11000;
    localparam logic [4:0] REQ_REACH     = 5'b00010;
    localparam logic [4:0] REQ_DELETE    = 5'b00001;

    localparam logic [47:0] MAC_ZERO  = 48'h0000_0000_0000;
    localparam logic [47:0] MAC_ONES  = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] MAC_A     = 48'h1234_5678_9ABC;
    localparam logic [47:0] MAC_B     = 48'hA5A5_A5A5_A5A5;
    localparam logic [47:0] MAC_C     = 48'h5A5A_5A5A_5A5A;
    localparam logic [47:0] MAC_LOW   = 48'h0000_0000_0001;

    localparam int NUM_PHASES      = 7;
    localparam int WORDS_PER_PHASE = 172;
    localparam int MAX_REPORTS     = 10;

    typedef struct {
        t_event  ev;
        bit      typed;
        t_result res;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_operation;
    logic [47:0] i_peer_mac;
    logic        i_solicited_flag;
    logic        i_override_flag;
    logic        i_route_already_absent;
    logic [2:0]  i_forced_state;
    logic [3:0]  i_forced_retry;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_cur_state;
    logic [2:0]  o_prior_state;
    logic [47:0] o_cached_mac;
    logic [3:0]  o_retries;
    logic        o_send_solicit;
    logic        o_start_retransmit;
    logic        o_start_delay;
    logic        o_start_reachable;
    logic        o_delete_route;
    logic        o_resolved;

    t_cfg        cfg;
    t_state      nb_state;
    t_state      nb_prior;
    logic [47:0] nb_mac;
    logic [3:0]  nb_retries;
    t_result     expected_words[$];
    t_dir_row    dir_rows[$];
    int          n_mismatch = 0;
    int          send_idle_pct = 0;
    int          rx_stall_pct = 0;

    ipv6_neighbor_state_machine dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    function automatic void enter_state(input t_state nxt, inout t_result r);
        if (nxt != nb_state) begin
            nb_prior = nb_state;
            nb_state = nxt;
        end
        case (nxt)
            ST_INCOMPLETE, ST_DELAY, ST_PROBE: nb_retries = '0;
            ST_REACHABLE: if (cfg.reachable_ms != '0) r.start_reachable = 1'b1;
            default: ;
        endcase
    endfunction

    function automatic void arm_retransmit(inout t_result r);
        if (cfg.retransmit_ms != '0) begin
            if (nb_retries != RETRY_MAX) nb_retries = nb_retries + 4'd1;
            r.start_retransmit = 1'b1;
        end
    endfunction

    function automatic t_result predict_event(input t_event ev);
        t_result r;
        logic    differs;
        r = '0;
        differs = (ev.peer_mac != nb_mac);
        case (ev.operation)
            OP_NS_IN: begin
                if (nb_state == ST_NONE) begin
                    nb_mac = ev.peer_mac;
                    enter_state(ST_STALE, r);
                end else if (nb_state == ST_STALE) begin
                    nb_mac = ev.peer_mac;
                end else if (differs) begin
                    nb_mac = ev.peer_mac;
                    enter_state(ST_STALE, r);
                end
            end
            OP_NA_IN: begin
                if (nb_state == ST_INCOMPLETE) begin
                    nb_mac = ev.peer_mac;
                    enter_state(ev.solicited_flag ? ST_REACHABLE : ST_STALE, r);
                end else if (nb_state == ST_NONE) begin
                end else if (!ev.solicited_flag) begin
                    if (ev.override_flag && differs) begin
                        nb_mac = ev.peer_mac;
                        enter_state(ST_STALE, r);
                    end
                end else if (nb_state == ST_REACHABLE) begin
                    if (!ev.override_flag) begin
                        if (differs) enter_state(ST_STALE, r);
                    end else begin
                        nb_mac = ev.peer_mac;
                    end
                end else if (ev.override_flag) begin
                    nb_mac = ev.peer_mac;
                    enter_state(ST_REACHABLE, r);
                end
            end
            OP_PKT_OUT: begin
                if (nb_state == ST_NONE) begin
                    r.send_solicit = 1'b1;
                    arm_retransmit(r);
                    enter_state(ST_INCOMPLETE, r);
                end else if (nb_state == ST_STALE) begin
                    if (cfg.delay_ms != '0) r.start_delay = 1'b1;
                    enter_state(ST_DELAY, r);
                end
            end
            OP_RETRANSMIT_EXP: begin
                if (nb_state == ST_INCOMPLETE || nb_state == ST_PROBE) begin
                    if (nb_retries < cfg.max_retries) begin
                        r.send_solicit = 1'b1;
                        arm_retransmit(r);
                    end else begin
                        r.delete_route = 1'b1;
                        if (!ev.route_already_absent) nb_retries = '0;
                    end
                end else if (nb_state == ST_REACHABLE) begin
                    if (nb_retries < cfg.max_retries) begin
                        r.send_solicit = 1'b1;
                        arm_retransmit(r);
                    end else begin
                        enter_state(ST_STALE, r);
                    end
                end
            end
            OP_DELAY_EXP: begin
                if (nb_state == ST_DELAY || nb_state == ST_PROBE) begin
                    r.send_solicit = 1'b1;
                    arm_retransmit(r);
                    enter_state(ST_PROBE, r);
                end
            end
            OP_REACHABLE_EXP: begin
                if (nb_state == ST_REACHABLE) enter_state(ST_STALE, r);
            end
            OP_FORCE_STATE: begin
                nb_mac = '0;
                if (nb_state == ST_STALE) nb_retries = ev.forced_retry;
                if (ev.forced_state <= ST_PROBE) enter_state(t_state'(ev.forced_state), r);
            end
            default: ;
        endcase
        r.cur_state   = nb_state;
        r.prior_state = nb_prior;
        r.cached_mac  = nb_mac;
        r.retries     = nb_retries;
        r.resolved    = (nb_state != ST_NONE) && (nb_state != ST_INCOMPLETE);
        return r;
    endfunction

    function automatic t_result mk_result(input t_state cs, input t_state ps,
                                          input logic [47:0] mac, input logic [3:0] rt,
                                          input logic [4:0] reqs, input logic res);
        t_result r;
        r.cur_state   = cs;
        r.prior_state = ps;
        r.cached_mac  = mac;
        r.retries     = rt;
        {r.send_solicit, r.start_retransmit, r.start_delay, r.start_reachable,
         r.delete_route} = reqs;
        r.resolved    = res;
        return r;
    endfunction

    function automatic t_dir_row mk_row(input logic [2:0] op, input logic [47:0] mac,
                                        input logic sol, input logic ovr,
                                        input logic absent, input logic [2:0] fst,
                                        input logic [3:0] fret, input bit typed,
                                        input t_result res);
        t_dir_row row;
        row.ev.operation            = op;
        row.ev.peer_mac             = mac;
        row.ev.solicited_flag       = sol;
        row.ev.override_flag        = ovr;
        row.ev.route_already_absent = absent;
        row.ev.forced_state         = fst;
        row.ev.forced_retry         = fret;
        row.typed                   = typed;
        row.res                     = res;
        return row;
    endfunction

    function automatic t_event rand_event();
        t_event ev;
        if ($urandom_range(99) < 80) begin
            case (nb_state)
                ST_NONE: ev.operation = ($urandom_range(3) == 0) ? OP_NS_IN : OP_PKT_OUT;
                ST_INCOMPLETE: begin
                    case ($urandom_range(9))
                        0:       ev.operation = OP_NS_IN;
                        1, 2:    ev.operation = OP_NA_IN;
                        default: ev.operation = OP_RETRANSMIT_EXP;
                    endcase
                end
                ST_REACHABLE: begin
                    case ($urandom_range(5))
                        0:       ev.operation = OP_NS_IN;
                        1:       ev.operation = OP_NA_IN;
                        2, 3:    ev.operation = OP_RETRANSMIT_EXP;
                        default: ev.operation = OP_REACHABLE_EXP;
                    endcase
                end
                ST_STALE: begin
                    case ($urandom_range(5))
                        0:       ev.operation = OP_NS_IN;
                        1:       ev.operation = OP_NA_IN;
                        2:       ev.operation = OP_FORCE_STATE;
                        default: ev.operation = OP_PKT_OUT;
                    endcase
                end
                ST_DELAY: ev.operation = ($urandom_range(3) == 0) ? OP_NA_IN : OP_DELAY_EXP;
                ST_PROBE: begin
                    case ($urandom_range(5))
                        0:       ev.operation = OP_NA_IN;
                        1:       ev.operation = OP_DELAY_EXP;
                        default: ev.operation = OP_RETRANSMIT_EXP;
                    endcase
                end
                default: ev.operation = OP_FORCE_STATE;
            endcase
        end else begin
            ev.operation = 3'($urandom_range(7));
        end
        case ($urandom_range(5))
            0, 1:    ev.peer_mac = nb_mac;
            2, 3:    ev.peer_mac = {16'($urandom), $urandom};
            4:       ev.peer_mac = {44'h0, 4'($urandom)};
            default: ev.peer_mac = $urandom_range(1) ? MAC_ONES : MAC_ZERO;
        endcase
        ev.solicited_flag       = 1'($urandom_range(1));
        ev.override_flag        = 1'($urandom_range(1));
        ev.route_already_absent = 1'($urandom_range(1));
        ev.forced_state = ($urandom_range(7) == 0) ? 3'($urandom_range(FST_UNDEF_HI, FST_UNDEF_LO))
                                                    : 3'($urandom_range(ST_PROBE));
        ev.forced_retry         = 4'($urandom_range(15));
        return ev;
    endfunction

    function automatic logic [15:0] rand_period();
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void check_result(input t_result got);
        t_result want;
        if (expected_words.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS)
                $display("%0t: result word with none expected: state %0d mac %h",
                         $realtime, got.cur_state, got.cached_mac);
        end else begin
            want = expected_words.pop_front();
            if (got.cur_state !== want.cur_state || got.prior_state !== want.prior_state ||
                got.cached_mac !== want.cached_mac || got.retries !== want.retries ||
                got.send_solicit !== want.send_solicit ||
                got.start_retransmit !== want.start_retransmit ||
                got.start_delay !== want.start_delay ||
                got.start_reachable !== want.start_reachable ||
                got.delete_route !== want.delete_route || got.resolved !== want.resolved) begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS) begin
                    $display("%0t: exp state %0d prior %0d mac %h retries %0d req %b res %b",
                             $realtime, want.cur_state, want.prior_state, want.cached_mac,
                             want.retries, {want.send_solicit, want.start_retransmit,
                             want.start_delay, want.start_reachable, want.delete_route},
                             want.resolved);
                    $display("%0t: got state %0d prior %0d mac %h retries %0d req %b res %b",
                             $realtime, got.cur_state, got.prior_state, got.cached_mac,
                             got.retries, {got.send_solicit, got.start_retransmit,
                             got.start_delay, got.start_reachable, got.delete_route},
                             got.resolved);
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall == 1'b0)
            check_result({o_cur_state, o_prior_state, o_cached_mac, o_retries,
                          o_send_solicit, o_start_retransmit, o_start_delay,
                          o_start_reachable, o_delete_route, o_resolved});
    end

    task automatic send_event(input t_event ev, input bit typed, input t_result typed_res);
        t_result r;
        i_in_valid             <= 1'b1;
        i_operation            <= ev.operation;
        i_peer_mac             <= ev.peer_mac;
        i_solicited_flag       <= ev.solicited_flag;
        i_override_flag        <= ev.override_flag;
        i_route_already_absent <= ev.route_already_absent;
        i_forced_state         <= ev.forced_state;
        i_forced_retry         <= ev.forced_retry;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        r = predict_event(ev);
        expected_words.push_back(typed ? typed_res : r);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            REG_RETRANSMIT:  cfg.retransmit_ms = value;
            REG_DELAY:       cfg.delay_ms      = value;
            REG_REACHABLE:   cfg.reachable_ms  = value;
            REG_MAX_RETRIES: cfg.max_retries   = value[3:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        #5_000_000;
        $display("** ipv6_neighbor_state_machine: FAILED **");
        $finish;
    end

    initial begin
        t_event ev;
        t_cfg   next_cfg;
        int     n_words;
        i_rst_n                <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        i_in_valid             <= 1'b0;
        i_operation            <= OP_NS_IN;
        i_peer_mac             <= '0;
        i_solicited_flag       <= 1'b0;
        i_override_flag        <= 1'b0;
        i_route_already_absent <= 1'b0;
        i_forced_state         <= '0;
        i_forced_retry         <= '0;
        cfg        = '{RETRANSMIT_RESET, DELAY_RESET, REACHABLE_RESET, MAX_RETRIES_RESET};
        nb_state   = ST_NONE;
        nb_prior   = ST_NONE;
        nb_mac     = '0;
        nb_retries = '0;

        dir_rows.push_back(mk_row(OP_PKT_OUT, MAC_ZERO, 1'b0, 1'b0, 1'b0, '0, '0, 1'b1,
            mk_result(ST_INCOMPLETE, ST_NONE, MAC_ZERO, 4'd0, REQ_SOLICIT, 1'b0)));
        repeat (6)
            dir_rows.push_back(mk_row(OP_RETRANSMIT_EXP, MAC_ZERO, 1'b0, 1'b0, 1'b0, '0, '0,
                1'b0, '0));
        dir_rows.push_back(mk_row(OP_RETRANSMIT_EXP, MAC_ZERO, 1'b0, 1'b0, 1'b1, '0, '0, 1'b1,
            mk_result(ST_INCOMPLETE, ST_NONE, MAC_ZERO, 4'd6, REQ_DELETE, 1'b0)));
        dir_rows.push_back(mk_row(OP_RETRANSMIT_EXP, MAC_ZERO, 1'b0, 1'b0, 1'b0, '0, '0, 1'b1,
            mk_result(ST_INCOMPLETE, ST_NONE, MAC_ZERO, 4'd0, REQ_DELETE, 1'b0)));
        dir_rows.push_back(mk_row(OP_NA_IN, MAC_ONES, 1'b1, 1'b0, 1'b0, '0, '0, 1'b1,
            mk_result(ST_REACHABLE, ST_INCOMPLETE, MAC_ONES, 4'd0, REQ_REACH, 1'b1)));
        dir_rows.push_back(mk_row(OP_NA_IN, MAC_A, 1'b1, 1'b0, 1'b0, '0, '0, 1'b0, '0));
        dir_rows.push_back(mk_row(OP_NS_IN, MAC_ZERO, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, '0));
        dir_rows.push_back(mk_row(OP_PKT_OUT, MAC_A, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, '0));
        dir_rows.push_back(mk_row(OP_DELAY_EXP, MAC_A, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, '0));
        dir_rows.push_back(mk_row(OP_NA_IN, MAC_B, 1'b1, 1'b1, 1'b0, '0, '0, 1'b0, '0));
        dir_rows.push_back(mk_row(OP_NA_IN, MAC_C, 1'b0, 1'b1, 1'b0, '0, '0, 1'b0, '0));
        dir_rows.push_back(mk_row(OP_FORCE_STATE, MAC_A, 1'b0, 1'b0, 1'b0, ST_STALE, 4'd15,
            1'b1, mk_result(ST_STALE, ST_REACHABLE, MAC_ZERO, 4'd15, REQ_NONE, 1'b1)));
        dir_rows.push_back(mk_row(OP_FORCE_STATE, MAC_A, 1'b0, 1'b0, 1'b0, FST_UNDEF_HI, 4'd9,
            1'b1, mk_result(ST_STALE, ST_REACHABLE, MAC_ZERO, 4'd9, REQ_NONE, 1'b1)));
        dir_rows.push_back(mk_row(OP_FORCE_STATE, MAC_A, 1'b0, 1'b0, 1'b0, ST_REACHABLE, 4'd15,
            1'b0, '0));
        dir_rows.push_back(mk_row(OP_RETRANSMIT_EXP, MAC_A, 1'b0, 1'b0, 1'b0, '0, '0,
            1'b0, '0));
        dir_rows.push_back(mk_row(OP_FORCE_STATE, MAC_A, 1'b0, 1'b0, 1'b0, FST_UNDEF_LO, 4'd0,
            1'b0, '0));
        dir_rows.push_back(mk_row(OP_FORCE_STATE, MAC_A, 1'b0, 1'b0, 1'b0, ST_NONE, 4'd15,
            1'b1, mk_result(ST_NONE, ST_STALE, MAC_ZERO, 4'd15, REQ_NONE, 1'b0)));
        dir_rows.push_back(mk_row(OP_UNDEFINED, MAC_ONES, 1'b1, 1'b1, 1'b1, ST_PROBE, 4'd15,
            1'b0, '0));
        dir_rows.push_back(mk_row(OP_PKT_OUT, MAC_ZERO, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, '0));
        dir_rows.push_back(mk_row(OP_NS_IN, MAC_LOW, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, '0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p <= 2) begin
                send_idle_pct = 20;
                rx_stall_pct  = 62;
            end else if (p <= 4) begin
                send_idle_pct = 62;
                rx_stall_pct  = 20;
            end else begin
                send_idle_pct = 0;
                rx_stall_pct  = 0;
            end
            if (p == 0) begin
                foreach (dir_rows[k])
                    send_event(dir_rows[k].ev, dir_rows[k].typed, dir_rows[k].res);
            end else begin
                drain();
                case (p)
                    1: next_cfg = '{16'h0000, 16'h0000, 16'h0000, 4'd0};
                    2: next_cfg = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15};
                    default: begin
                        next_cfg.retransmit_ms = rand_period();
                        next_cfg.delay_ms      = rand_period();
                        next_cfg.reachable_ms  = rand_period();
                        next_cfg.max_retries   = $urandom_range(1) ? 4'($urandom_range(3))
                                                                   : 4'($urandom_range(15));
                    end
                endcase
                write_reg(REG_RETRANSMIT, next_cfg.retransmit_ms);
                write_reg(REG_DELAY, next_cfg.delay_ms);
                write_reg(REG_REACHABLE, next_cfg.reachable_ms);
                write_reg(REG_MAX_RETRIES, {12'h000, next_cfg.max_retries});
            end
            n_words = 0;
            while (n_words < WORDS_PER_PHASE) begin
                ev = rand_event();
                send_event(ev, 1'b0, '0);
                n_words++;
            end
        end

        drain();
        if (n_mismatch == 0 && expected_words.size() == 0) begin
            $display("** ipv6_neighbor_state_machine: PASSED **");
        end else begin
            $display("** ipv6_neighbor_state_machine: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/nsm_pkg.sv
design/nsm_regs.sv
design/nsm_fsm.sv
design/ipv6_neighbor_state_machine.sv
design/nsm_checker.sv
verif/tb_top.sv
